// ===== hdl/integer_to_roman_numeral_core_assert.svh =====
// Assertion macros shared by the converter modules.
`ifndef INTEGER_TO_ROMAN_NUMERAL_CORE_ASSERT_SVH
`define INTEGER_TO_ROMAN_NUMERAL_CORE_ASSERT_SVH

// Checked outside reset only.
`define ITR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked in every cycle, reset included.
`define ITR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hdl/itr_pkg.sv =====
package itr_pkg;

   localparam int unsigned NUM_W     = 12;
   localparam int unsigned CHAR_W    = 8;
   localparam int unsigned ENTRIES   = 13;
   localparam int unsigned IDX_W     = 4;
   localparam logic [NUM_W-1:0] NUM_MAX_VALID = 12'd3999;

   localparam logic [CHAR_W-1:0] CHAR_I = 8'h49;
   localparam logic [CHAR_W-1:0] CHAR_V = 8'h56;
   localparam logic [CHAR_W-1:0] CHAR_X = 8'h58;
   localparam logic [CHAR_W-1:0] CHAR_L = 8'h4C;
   localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
   localparam logic [CHAR_W-1:0] CHAR_D = 8'h44;
   localparam logic [CHAR_W-1:0] CHAR_M = 8'h4D;
   localparam logic [CHAR_W-1:0] CHAR_NONE = 8'h00;

   typedef struct packed {
      logic load;      // take a new request into the datapath
      logic emit;      // push the current character into the output register
      logic emit_err;  // push the out-of-range result
      logic step_idx;  // move to the next table entry
   } itr_cmd_type;

   typedef struct packed {
      logic in_bad;    // offered number is 0 or above the valid range
      logic fits;      // remaining value is at least the current entry's weight
      logic run_end;   // the character now due is the final one
      logic slot_free; // output register can take a character this cycle
   } itr_sts_type;

   function automatic logic [NUM_W-1:0] entry_weight(input logic [IDX_W-1:0] idx);
      logic [NUM_W-1:0] w;
      unique case (idx)
         4'd0:    w = 12'd1000;
         4'd1:    w = 12'd900;
         4'd2:    w = 12'd500;
         4'd3:    w = 12'd400;
         4'd4:    w = 12'd100;
         4'd5:    w = 12'd90;
         4'd6:    w = 12'd50;
         4'd7:    w = 12'd40;
         4'd8:    w = 12'd10;
         4'd9:    w = 12'd9;
         4'd10:   w = 12'd5;
         4'd11:   w = 12'd4;
         default: w = 12'd1;
      endcase
      return w;
   endfunction

   function automatic logic [CHAR_W-1:0] entry_ch0(input logic [IDX_W-1:0] idx);
      logic [CHAR_W-1:0] c;
      unique case (idx)
         4'd0:    c = CHAR_M;
         4'd1:    c = CHAR_C;
         4'd2:    c = CHAR_D;
         4'd3:    c = CHAR_C;
         4'd4:    c = CHAR_C;
         4'd5:    c = CHAR_X;
         4'd6:    c = CHAR_L;
         4'd7:    c = CHAR_X;
         4'd8:    c = CHAR_X;
         4'd9:    c = CHAR_I;
         4'd10:   c = CHAR_V;
         4'd11:   c = CHAR_I;
         default: c = CHAR_I;
      endcase
      return c;
   endfunction

   function automatic logic [CHAR_W-1:0] entry_ch1(input logic [IDX_W-1:0] idx);
      logic [CHAR_W-1:0] c;
      unique case (idx)
         4'd1:    c = CHAR_M;
         4'd3:    c = CHAR_D;
         4'd5:    c = CHAR_C;
         4'd7:    c = CHAR_L;
         4'd9:    c = CHAR_X;
         4'd11:   c = CHAR_V;
         default: c = CHAR_NONE;
      endcase
      return c;
   endfunction

   // Two-character entries sit at the odd places of the table.
   function automatic logic entry_two(input logic [IDX_W-1:0] idx);
      return idx[0] && (idx < IDX_W'(ENTRIES));
   endfunction

endpackage

// ===== hdl/itr_ctrl.sv =====
`include "integer_to_roman_numeral_core_assert.svh"

module itr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  itr_pkg::itr_sts_type sts,
   output itr_pkg::itr_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_ERR  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = sts.in_bad ? ST_ERR : ST_RUN;
            end
         end
         ST_RUN: begin
            if (sts.fits) begin
               if (sts.slot_free) begin
                  cmd.emit = 1'b1;
                  if (sts.run_end) begin
                     state_in = ST_IDLE;
                  end
               end
            end else begin
               cmd.step_idx = 1'b1;
            end
         end
         ST_ERR: begin
            if (sts.slot_free) begin
               cmd.emit_err = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `ITR_ASSERT(a_emit_needs_slot, (cmd.emit || cmd.emit_err) |-> sts.slot_free, "emit into full slot")
   `ITR_ASSERT(a_accept_leaves_idle, (req_tvalid && req_tready) |=> (state_ff != ST_IDLE), "request accepted but controller stayed idle")
   `ITR_ASSERT(a_err_only_bad, (cmd.load && !sts.in_bad) |=> (state_ff == ST_RUN), "valid request not converted")
   `ITR_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == ST_IDLE), "controller not idle after reset")

endmodule

// ===== hdl/itr_dp.sv =====
`include "integer_to_roman_numeral_core_assert.svh"

module itr_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [itr_pkg::NUM_W-1:0]           number,
   input  itr_pkg::itr_cmd_type                cmd,
   output itr_pkg::itr_sts_type                sts,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [itr_pkg::CHAR_W-1:0]          rsp_char,
   output logic                                rsp_last,
   output logic                                rsp_err
);

   logic [itr_pkg::NUM_W-1:0]  rest_ff, rest_in;
   logic [itr_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic                       second_ff, second_in;
   logic                       valid_ff, valid_in;
   logic [itr_pkg::CHAR_W-1:0] char_ff, char_in;
   logic                       last_ff, last_in;
   logic                       err_ff, err_in;

   logic [itr_pkg::NUM_W-1:0]  weight;
   logic                       two;

   assign weight = itr_pkg::entry_weight(idx_ff);
   assign two    = itr_pkg::entry_two(idx_ff);

   always_comb begin
      sts.in_bad    = (number == '0) || (number > itr_pkg::NUM_MAX_VALID);
      sts.fits      = (rest_ff >= weight);
      sts.run_end   = (rest_ff == weight) && (!two || second_ff);
      sts.slot_free = !valid_ff || rsp_tready;
   end

   always_comb begin
      rest_in   = rest_ff;
      idx_in    = idx_ff;
      second_in = second_ff;
      valid_in  = valid_ff && !rsp_tready;
      char_in   = char_ff;
      last_in   = last_ff;
      err_in    = err_ff;
      if (cmd.load) begin
         rest_in   = number;
         idx_in    = '0;
         second_in = 1'b0;
      end
      if (cmd.step_idx) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.emit) begin
         valid_in = 1'b1;
         char_in  = second_ff ? itr_pkg::entry_ch1(idx_ff) : itr_pkg::entry_ch0(idx_ff);
         last_in  = sts.run_end;
         err_in   = 1'b0;
         if (two && !second_ff) begin
            second_in = 1'b1;
         end else begin
            second_in = 1'b0;
            rest_in   = rest_ff - weight;
         end
      end
      if (cmd.emit_err) begin
         valid_in = 1'b1;
         char_in  = itr_pkg::CHAR_NONE;
         last_in  = 1'b1;
         err_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
      rest_ff   <= rest_in;
      idx_ff    <= idx_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
      err_ff    <= err_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_char   = char_ff;
   assign rsp_last   = last_ff;
   assign rsp_err    = err_ff;

   `ITR_ASSERT(a_err_shape, (valid_ff && err_ff) |-> (last_ff && !(|char_ff)), "bad error result")
   `ITR_ASSERT(a_second_on_pair, second_ff |-> two, "second character on a single entry")

endmodule

// ===== hdl/integer_to_roman_numeral_core.sv =====
// Channel | Ports      | Payload
// request | req_*      | tdata[11:0] number, [15:12] zero
// result  | rsp_*      | tdata[7:0] symbol_char, tlast last, tuser[0] error
//
// A request is taken only while idle. The single compare-subtract stage then walks
// the table greedily: it emits a character while the entry fits and the output slot
// is free, else passes to the next entry. An out-of-range value gives one error result.
// Reset clears the controller and the output valid. A stalled result holds back the
// next character; the next request is taken while the final character waits.

module integer_to_roman_numeral_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] number, [15:12] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] symbol_char
   output logic        rsp_tlast,
   output logic [0:0]  rsp_tuser    // [0] error
);

   itr_pkg::itr_cmd_type cmd;
   itr_pkg::itr_sts_type sts;
   logic                 rsp_err;

   itr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   itr_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .number     (req_tdata[itr_pkg::NUM_W-1:0]),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_char   (rsp_tdata),
      .rsp_last   (rsp_tlast),
      .rsp_err    (rsp_err)
   );

   assign rsp_tuser = rsp_err;

endmodule

// ===== verif/tb_integer_to_roman_numeral_core.sv =====
module tb_integer_to_roman_numeral_core;

   typedef struct {
      logic [itr_pkg::CHAR_W-1:0] symbol;
      logic                       last;
      logic                       error;
   } numeral_char_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [11:0] number, [15:12] zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [7:0] symbol_char
   logic        rsp_tlast;
   logic [0:0]  rsp_tuser;   // [0] error

   numeral_char_type expected_chars[$];
   int unsigned      fail_count;
   int unsigned      send_idle_pct;
   int unsigned      recv_stall_pct;
   logic             hold_active;

   int unsigned numeral_weight[13] = '{1000, 900, 500, 400, 100, 90, 50, 40, 10, 9,
                                       5, 4, 1};
   logic [itr_pkg::CHAR_W-1:0] lead_char[13] = '{
      itr_pkg::CHAR_M, itr_pkg::CHAR_C, itr_pkg::CHAR_D, itr_pkg::CHAR_C, itr_pkg::CHAR_C,
      itr_pkg::CHAR_X, itr_pkg::CHAR_L, itr_pkg::CHAR_X, itr_pkg::CHAR_X, itr_pkg::CHAR_I,
      itr_pkg::CHAR_V, itr_pkg::CHAR_I, itr_pkg::CHAR_I};
   logic [itr_pkg::CHAR_W-1:0] trail_char[13] = '{
      itr_pkg::CHAR_NONE, itr_pkg::CHAR_M, itr_pkg::CHAR_NONE, itr_pkg::CHAR_D,
      itr_pkg::CHAR_NONE, itr_pkg::CHAR_C, itr_pkg::CHAR_NONE, itr_pkg::CHAR_L,
      itr_pkg::CHAR_NONE, itr_pkg::CHAR_X, itr_pkg::CHAR_NONE, itr_pkg::CHAR_V,
      itr_pkg::CHAR_NONE};

   integer_to_roman_numeral_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("== FAIL ==");
      $finish;
   end

   // Greedy expansion of one number into its expected character run, or one error result.
   function automatic void predict_numeral(input logic [itr_pkg::NUM_W-1:0] number);
      int unsigned                remaining;
      int unsigned                idx;
      logic [itr_pkg::CHAR_W-1:0] chars[$];
      remaining = number;
      idx = 0;
      if (number == 0 || number > itr_pkg::NUM_MAX_VALID) begin
         expected_chars.push_back('{itr_pkg::CHAR_NONE, 1'b1, 1'b1});
         return;
      end
      while (remaining > 0) begin
         if (remaining >= numeral_weight[idx]) begin
            chars.push_back(lead_char[idx]);
            if (trail_char[idx] != itr_pkg::CHAR_NONE) chars.push_back(trail_char[idx]);
            remaining -= numeral_weight[idx];
         end else begin
            idx++;
         end
      end
      foreach (chars[k]) expected_chars.push_back('{chars[k], k == chars.size() - 1, 1'b0});
   endfunction

   function automatic void note_failure(input string msg);
      if (fail_count < 10) $display("%s", msg);
      fail_count++;
   endfunction

   always @(posedge clock) begin : check_results
      numeral_char_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_chars.size() == 0) begin
            note_failure($sformatf("unexpected result: char %h last %b error %b",
                                   rsp_tdata, rsp_tlast, rsp_tuser[0]));
         end else begin
            want = expected_chars.pop_front();
            if (rsp_tdata !== want.symbol || rsp_tlast !== want.last
                || rsp_tuser[0] !== want.error)
               note_failure($sformatf(
                  "mismatch: exp char %h last %b error %b, got char %h last %b error %b",
                  want.symbol, want.last, want.error, rsp_tdata, rsp_tlast, rsp_tuser[0]));
         end
      end
   end

   always @(posedge clock) begin
      if (hold_active) rsp_tready <= 1'b0;
      else             rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic send_number(input logic [itr_pkg::NUM_W-1:0] number);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, number};
      do @(posedge clock); while (!req_tready);
      predict_numeral(number);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [itr_pkg::NUM_W-1:0] random_number();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 5)  return '0;
      if (pick < 15) return itr_pkg::NUM_W'($urandom_range(4000, 4095));
      return itr_pkg::NUM_W'($urandom_range(1, 3999));
   endfunction

   task automatic test_directed_values();
      logic [itr_pkg::NUM_W-1:0] values[$];
      values = '{12'd1, 12'd3999, 12'd0, 12'd4000, 12'd4095, 12'd3888, 12'd2048, 12'd4,
                 12'd9, 12'd40, 12'd90, 12'd400, 12'd900, 12'd1000, 12'd5, 12'd50,
                 12'd500, 12'd1994, 12'd1365, 12'd2730, 12'd3, 12'd444, 12'd999,
                 12'd2222};
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      foreach (values[i]) send_number(values[i]);
      drain_results();
   endtask

   task automatic test_random_numbers(input int unsigned count, input int unsigned idle_pct,
                                      input int unsigned stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) send_number(random_number());
      drain_results();
   endtask

   // Receiver holds off long enough for requests to back up into the core.
   task automatic test_output_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      fork
         begin
            hold_active <= 1'b1;
            repeat (120) @(posedge clock);
            hold_active <= 1'b0;
         end
      join_none
      repeat (12) send_number($urandom_range(2) == 0 ? 12'd3888 : random_number());
      drain_results();
   endtask

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      rsp_tready     = 1'b1;
      hold_active    = 1'b0;
      fail_count     = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_values();
      test_random_numbers(60, 0, 0);
      test_random_numbers(60, 74, 0);
      test_random_numbers(60, 0, 74);
      test_random_numbers(60, 17, 17);
      test_output_backpressure();

      if (fail_count == 0) $display("== PASS ==");
      else                 $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/itr_pkg.sv
hdl/itr_ctrl.sv
hdl/itr_dp.sv
hdl/integer_to_roman_numeral_core.sv
verif/tb_integer_to_roman_numeral_core.sv
